>>> hdl/lasc_pkg.sv
// Shared types and constants for the lookahead spike corrector.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
`default_nettype none

package lasc_pkg;

    localparam int THR_BITS       = 15;
    localparam int LIM_BITS       = 4;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 15;
    localparam int DIVISOR_BITS   = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ERROR_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_SEARCH      = 1'd1;

    localparam logic [THR_BITS-1:0] THR_RESET = 15'd640;
    localparam logic [LIM_BITS-1:0] LIM_RESET = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_CMP,
        ST_DIV,
        ST_EMIT
    } lasc_state_t;

endpackage

`default_nettype wire

>>> hdl/lasc_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on lasc_pkg for the register port widths.
`default_nettype none

interface lasc_sample_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          last_sample;

    modport source (output valid, output sample_value, output last_sample, input ready);
    modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface lasc_result_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] corrected_value;
    logic                          was_changed;
    logic                          limit_hit;
    logic                          last_result;

    modport source (output valid, output corrected_value, output was_changed,
                    output limit_hit, output last_result, input ready);
    modport sink   (input valid, input corrected_value, input was_changed,
                    input limit_hit, input last_result, output ready);
endinterface

interface lasc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lasc_pkg::CFG_INDEX_BITS-1:0] index;
    logic [lasc_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/lookahead_spike_corrector.sv
// Lookahead spike corrector top level: sample buffer, search sequencer, output register.
// Depends on lasc_pkg, the channel interfaces in lasc_if.sv and the divider lasc_div.
//
// Each sample transaction is taken only while the block is idle. A sample is
// buffered until max_search samples follow it (or the stream ends), then its
// forward search runs one step at a time, a FETCH then a CMP state, through
// the single buffer read port and one shared compare against a running
// (k+1)*threshold bound. The first sample of a stream is released without a
// search. An interpolated result then passes through the bit-serial divider.
// Each result waits in the output register until it is taken. Typical
// streams release one result per sample. No clearing pass.
`default_nettype none

module lookahead_spike_corrector #(
    parameter int WINDOW_DEPTH = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lasc_sample_if.sink   samples,
    lasc_result_if.source results,
    lasc_cfg_if.sink      cfg
);

    localparam int THR_W   = lasc_pkg::THR_BITS;
    localparam int LIM_W   = lasc_pkg::LIM_BITS;
    localparam int PTR_W   = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CW      = (CNT_W > LIM_W + 1) ? CNT_W : LIM_W + 1;
    localparam int DW      = SAMPLE_BITS + 1;
    localparam int BND_W   = THR_W + LIM_W;
    localparam int CMP_W   = (DW > BND_W) ? DW : BND_W;
    localparam int LIM_CAP = (WINDOW_DEPTH - 1 < 15) ? WINDOW_DEPTH - 1 : 15;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(LIM_CAP);

    lasc_pkg::lasc_state_t state_reg, state_next;

    logic [THR_W-1:0]       thr_reg;
    logic [LIM_W-1:0]       ms_reg;
    logic [SAMPLE_BITS-1:0] prev_reg,  prev_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PTR_W-1:0]       rp_reg,    rp_next;
    logic                   first_reg, first_next;
    logic                   last_reg,  last_next;

    logic [LIM_W-1:0]       s_reg,     s_next;
    logic [BND_W-1:0]       bound_reg, bound_next;
    logic [PTR_W-1:0]       srch_reg,  srch_next;
    logic [SAMPLE_BITS-1:0] head_reg,  head_next;
    logic                   neg_reg,   neg_next;
    logic [SAMPLE_BITS-1:0] val_reg,   val_next;
    logic                   chg_reg,   chg_next;
    logic                   hit_reg,   hit_next;

    logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic                   in_take;
    logic [SUM_W-1:0]       wsum;
    logic [PTR_W-1:0]       wr_addr;
    logic [LIM_W-1:0]       lim;
    logic [LIM_W:0]         s_plus1;
    logic                   flush_stop;
    logic [DW-1:0]          diff;
    logic [DW-1:0]          absd;
    logic                   in_band;
    logic                   emit_now;
    logic                   div_start;
    logic                   div_done;
    logic [DW-1:0]          quo;
    logic [DW-1:0]          quo_s;
    logic [DW-1:0]          interp;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign in_take = samples.valid && samples.ready;

    always_comb
    begin
        wsum = SUM_W'(rp_reg) + SUM_W'(count_reg);
        if (wsum >= SUM_W'(WINDOW_DEPTH))
        begin
            wsum = wsum - SUM_W'(WINDOW_DEPTH);
        end
        wr_addr = wsum[PTR_W-1:0];
    end

    always_comb
    begin
        if (ms_reg == '0)
        begin
            lim = LIM_W'(1);
        end
        else if (ms_reg > LIM_MAX)
        begin
            lim = LIM_MAX;
        end
        else
        begin
            lim = ms_reg;
        end
    end

    always_comb
    begin
        s_plus1    = {1'b0, s_reg} + 1'b1;
        flush_stop = last_reg && (CW'(s_plus1) >= CW'(count_reg));
        diff       = {rd_data_reg[SAMPLE_BITS-1], rd_data_reg}
                   - {prev_reg[SAMPLE_BITS-1], prev_reg};
        absd       = diff[DW-1] ? (~diff + 1'b1) : diff;
        in_band    = CMP_W'(absd) <= CMP_W'(bound_reg);
        emit_now   = (count_reg != '0)
                  && (first_reg || last_reg || (CW'(count_reg) > CW'(lim)));
        quo_s      = neg_reg ? (~quo + 1'b1) : quo;
        interp     = {prev_reg[SAMPLE_BITS-1], prev_reg} + quo_s;
    end

    assign div_start = (state_reg == lasc_pkg::ST_CMP) && !first_reg
                    && (flush_stop || in_band) && (s_reg != '0);

    lasc_div #(
        .WIDTH (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (absd),
        .divisor  (s_plus1),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lasc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = lasc_pkg::ST_CHECK;
                end
            end
            lasc_pkg::ST_CHECK:
            begin
                state_next = emit_now ? lasc_pkg::ST_FETCH : lasc_pkg::ST_IDLE;
            end
            lasc_pkg::ST_FETCH:
            begin
                state_next = lasc_pkg::ST_CMP;
            end
            lasc_pkg::ST_CMP:
            begin
                if (first_reg)
                begin
                    state_next = lasc_pkg::ST_EMIT;
                end
                else if (flush_stop || in_band)
                begin
                    state_next = (s_reg == '0) ? lasc_pkg::ST_EMIT : lasc_pkg::ST_DIV;
                end
                else if (s_plus1[LIM_W-1:0] == lim)
                begin
                    state_next = lasc_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = lasc_pkg::ST_FETCH;
                end
            end
            lasc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = lasc_pkg::ST_EMIT;
                end
            end
            lasc_pkg::ST_EMIT:
            begin
                if (results.ready)
                begin
                    if (last_reg && (count_reg == CNT_W'(1)))
                    begin
                        state_next = lasc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lasc_pkg::ST_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = lasc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        prev_next  = prev_reg;
        count_next = count_reg;
        rp_next    = rp_reg;
        first_next = first_reg;
        last_next  = last_reg;
        s_next     = s_reg;
        bound_next = bound_reg;
        srch_next  = srch_reg;
        head_next  = head_reg;
        neg_next   = neg_reg;
        val_next   = val_reg;
        chg_next   = chg_reg;
        hit_next   = hit_reg;
        unique case (state_reg)
            lasc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    last_next  = samples.last_sample;
                    count_next = count_reg + 1'b1;
                end
            end
            lasc_pkg::ST_CHECK:
            begin
                s_next     = '0;
                bound_next = BND_W'(thr_reg);
                srch_next  = rp_reg;
            end
            lasc_pkg::ST_FETCH:
            begin
            end
            lasc_pkg::ST_CMP:
            begin
                if (s_reg == '0)
                begin
                    head_next = rd_data_reg;
                end
                neg_next = diff[DW-1];
                chg_next = 1'b0;
                hit_next = 1'b0;
                if (first_reg || ((flush_stop || in_band) && (s_reg == '0)))
                begin
                    val_next = rd_data_reg;
                end
                else if (flush_stop || in_band)
                begin
                    chg_next = 1'b1;
                end
                else if (s_plus1[LIM_W-1:0] == lim)
                begin
                    val_next = head_next;
                    hit_next = 1'b1;
                end
                else
                begin
                    s_next     = s_plus1[LIM_W-1:0];
                    bound_next = bound_reg + BND_W'(thr_reg);
                    srch_next  = ptr_inc(srch_reg);
                end
            end
            lasc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    val_next = interp[SAMPLE_BITS-1:0];
                end
            end
            lasc_pkg::ST_EMIT:
            begin
                if (results.ready)
                begin
                    prev_next  = val_reg;
                    first_next = 1'b0;
                    rp_next    = ptr_inc(rp_reg);
                    count_next = count_reg - 1'b1;
                    if (last_reg && (count_reg == CNT_W'(1)))
                    begin
                        first_next = 1'b1;
                        prev_next  = '0;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lasc_pkg::ST_IDLE;
            thr_reg   <= lasc_pkg::THR_RESET;
            ms_reg    <= lasc_pkg::LIM_RESET;
            prev_reg  <= '0;
            count_reg <= '0;
            rp_reg    <= '0;
            first_reg <= 1'b1;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
            rp_reg    <= rp_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    lasc_pkg::REG_ERROR_THRESHOLD: thr_reg <= cfg.data[THR_W-1:0];
                    lasc_pkg::REG_MAX_SEARCH:      ms_reg  <= cfg.data[LIM_W-1:0];
                    default:                       ms_reg  <= ms_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        bound_reg <= bound_next;
        srch_reg  <= srch_next;
        head_reg  <= head_next;
        neg_reg   <= neg_next;
        val_reg   <= val_next;
        chg_reg   <= chg_next;
        hit_reg   <= hit_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mem[wr_addr] <= samples.sample_value;
        end
        rd_data_reg <= mem[srch_reg];
    end

    assign samples.ready = (state_reg == lasc_pkg::ST_IDLE);
    assign cfg.ready     = 1'b1;

    assign results.valid           = (state_reg == lasc_pkg::ST_EMIT);
    assign results.corrected_value = val_reg;
    assign results.was_changed     = chg_reg;
    assign results.limit_hit       = hit_reg;
    assign results.last_result     = last_reg && (count_reg == CNT_W'(1));

endmodule

`default_nettype wire

>>> hdl/lasc_div.sv
// Bit-serial restoring divider: unsigned dividend by a small step count.
// Depends on lasc_pkg for the divisor width.
`default_nettype none

module lasc_div #(
    parameter int WIDTH = 17
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [WIDTH-1:0]                  dividend,
    input  wire logic [lasc_pkg::DIVISOR_BITS-1:0] divisor,
    output logic                                   done,
    output logic [WIDTH-1:0]                       quotient
);

    localparam int DB    = lasc_pkg::DIVISOR_BITS;
    localparam int CNT_W = $clog2(WIDTH + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] q_reg;
    logic [DB-1:0]    rem_reg;
    logic [DB-1:0]    dvs_reg;

    logic [DB:0]      rem_shift;
    logic [DB:0]      rem_diff;
    logic             fits;
    logic [DB-1:0]    rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, q_reg[WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_next  = fits ? rem_diff[DB-1:0] : rem_shift[DB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[WIDTH-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire
